// ===== sv/assert_macros.svh =====
// ----------------------------------------------------------------------------
// assert_macros.svh
// Assertion helpers shared by the RTL; they compile away under SYNTH.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTH

// Clocked property, disabled while reset is asserted
`define ASSERT_CLK(lbl, clk, rstn, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);

// Condition that must never hold outside reset
`define ASSERT_NEVER(lbl, clk, rstn, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) !(cond)) else $error(msg);

`else

`define ASSERT_CLK(lbl, clk, rstn, prop, msg)
`define ASSERT_NEVER(lbl, clk, rstn, cond, msg)

`endif

`endif

// ===== sv/cwbu_pkg.sv =====
// ----------------------------------------------------------------------------
// cwbu_pkg
// Widths, reset values and register indexes of the backoff update unit.
// ----------------------------------------------------------------------------
package cwbu_pkg;

    localparam int WIN_W = 16;
    localparam int CNT_W = 32;
    localparam int SUM_W = 48;

    localparam logic [WIN_W-1:0] START_WINDOW_RST    = 16'd32;
    localparam logic [WIN_W-1:0] START_THRESHOLD_RST = 16'd512;
    localparam logic [WIN_W-1:0] BASE_WINDOW_RST     = 16'd32;
    localparam logic [WIN_W-1:0] MAX_WINDOW_RST      = 16'd1024;

    // Configuration register indexes
    localparam int REG_START_WINDOW    = 0;
    localparam int REG_START_THRESHOLD = 1;
    localparam int REG_BASE_WINDOW     = 2;
    localparam int REG_MAX_WINDOW      = 3;

    typedef logic [WIN_W-1:0] win_t;
    typedef logic [CNT_W-1:0] cnt_t;
    typedef logic [SUM_W-1:0] sum_t;

endpackage

// ===== sv/contention_window_backoff_update_unit.sv =====
// ----------------------------------------------------------------------------
// contention_window_backoff_update_unit
// Binary exponential backoff with threshold: per frame outcome, updates the
// contention window, its threshold and the running statistics.
// ----------------------------------------------------------------------------
// The unit takes one frame outcome per clock and returns one result per
// outcome, registered in the cycle after the request is accepted. The window,
// threshold and counters are updated from their current values, and they
// double as the result register, so a new request can follow in the very next
// cycle; out_ready low holds the result and stalls in_ready. Configuration
// writes are always ready; writing start_window or start_threshold also
// reloads the live window or threshold, and the counters keep their values.
module contention_window_backoff_update_unit
    import cwbu_pkg::*;
#(
    parameter int CFG_INDEX_W = 8
)
(
    input  logic                   clk,
    input  logic                   rst_n,

    input  logic                   cfg_valid,
    output logic                   cfg_ready,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [WIN_W-1:0]       cfg_data,

    input  logic                   in_valid,
    output logic                   in_ready,
    input  logic                   frame_ok,

    output logic                   out_valid,
    input  logic                   out_ready,
    output logic [WIN_W-1:0]       window,
    output logic [WIN_W-1:0]       threshold,
    output logic                   frame_lost,
    output logic [CNT_W-1:0]       success_total,
    output logic [CNT_W-1:0]       failure_total,
    output logic [CNT_W-1:0]       lost_total,
    output logic [SUM_W-1:0]       backoff_slots_total
);

`include "assert_macros.svh"

    win_t base_window_reg, max_window_reg;
    win_t cur_window_reg,   cur_window_next;
    win_t cur_threshold_reg, cur_threshold_next;
    cnt_t ok_count_reg,     ok_count_next;
    cnt_t fail_count_reg,   fail_count_next;
    cnt_t loss_count_reg,   loss_count_next;
    sum_t slot_sum_reg,     slot_sum_next;
    logic lost_reg,         lost_next;
    logic out_valid_reg;

    logic               accept;
    logic               cfg_we;
    logic [WIN_W:0]     dbl_win;
    logic [WIN_W:0]     add_win;
    logic [WIN_W:0]     dec_step;
    logic [WIN_W:0]     new_thr;
    logic [SUM_W:0]     sum_add;

    assign cfg_ready = 1'b1;
    assign cfg_we    = cfg_valid & cfg_ready;
    assign in_ready  = ~out_valid_reg | out_ready;
    assign accept    = in_valid & in_ready;

    assign dbl_win  = {cur_window_reg, 1'b0};
    assign add_win  = {1'b0, cur_window_reg} + {1'b0, base_window_reg};
    assign dec_step = {base_window_reg, 1'b0};
    assign new_thr  = {cur_threshold_reg, 1'b1};

    always_comb
    begin
        cur_window_next    = cur_window_reg;
        cur_threshold_next = cur_threshold_reg;
        ok_count_next      = ok_count_reg;
        fail_count_next    = fail_count_reg;
        loss_count_next    = loss_count_reg;
        lost_next          = 1'b0;

        if (frame_ok)
        begin
            ok_count_next = (ok_count_reg == '1) ? ok_count_reg : ok_count_reg + 1'b1;
            if (cur_window_reg <= cur_threshold_reg)
            begin
                if (cur_window_reg != base_window_reg)
                    cur_window_next = cur_window_reg >> 1;
            end
            else
            begin
                // Drop by twice the base window, clamp at zero
                if ({1'b0, cur_window_reg} > dec_step)
                    cur_window_next = cur_window_reg - dec_step[WIN_W-1:0];
                else
                    cur_window_next = '0;
            end
        end
        else
        begin
            fail_count_next = (fail_count_reg == '1) ? fail_count_reg : fail_count_reg + 1'b1;
            if (cur_window_reg < cur_threshold_reg)
            begin
                cur_window_next = dbl_win[WIN_W] ? '1 : dbl_win[WIN_W-1:0];
                if (cur_window_next >= cur_threshold_reg)
                begin
                    if (new_thr >= {1'b0, max_window_reg})
                        cur_threshold_next = max_window_reg;
                    else
                        cur_threshold_next = new_thr[WIN_W-1:0];
                end
            end
            else
            begin
                lost_next       = 1'b1;
                loss_count_next = (loss_count_reg == '1) ? loss_count_reg
                                                         : loss_count_reg + 1'b1;
                if (cur_window_reg != max_window_reg)
                    cur_window_next = add_win[WIN_W] ? '1 : add_win[WIN_W-1:0];
            end
        end
    end

    assign sum_add       = {1'b0, slot_sum_reg} + {{(SUM_W-WIN_W+1){1'b0}}, cur_window_next};
    assign slot_sum_next = sum_add[SUM_W] ? '1 : sum_add[SUM_W-1:0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            base_window_reg     <= BASE_WINDOW_RST;
            max_window_reg      <= MAX_WINDOW_RST;
            cur_window_reg      <= START_WINDOW_RST;
            cur_threshold_reg   <= START_THRESHOLD_RST;
            ok_count_reg        <= '0;
            fail_count_reg      <= '0;
            loss_count_reg      <= '0;
            slot_sum_reg        <= '0;
            lost_reg            <= 1'b0;
            out_valid_reg       <= 1'b0;
        end
        else
        begin
            if (accept)
            begin
                cur_window_reg    <= cur_window_next;
                cur_threshold_reg <= cur_threshold_next;
                ok_count_reg      <= ok_count_next;
                fail_count_reg    <= fail_count_next;
                loss_count_reg    <= loss_count_next;
                slot_sum_reg      <= slot_sum_next;
                lost_reg          <= lost_next;
                out_valid_reg     <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end

            if (cfg_we)
            begin
                case (cfg_index)
                    CFG_INDEX_W'(REG_START_WINDOW):
                        cur_window_reg <= cfg_data;
                    CFG_INDEX_W'(REG_START_THRESHOLD):
                        cur_threshold_reg <= cfg_data;
                    CFG_INDEX_W'(REG_BASE_WINDOW):
                        base_window_reg <= cfg_data;
                    CFG_INDEX_W'(REG_MAX_WINDOW):
                        max_window_reg <= cfg_data;
                    default:
                        ; // drop writes to unknown indexes
                endcase
            end
        end
    end

    assign out_valid           = out_valid_reg;
    assign window              = cur_window_reg;
    assign threshold           = cur_threshold_reg;
    assign frame_lost          = lost_reg;
    assign success_total       = ok_count_reg;
    assign failure_total       = fail_count_reg;
    assign lost_total          = loss_count_reg;
    assign backoff_slots_total = slot_sum_reg;

    logic ok_accept;
    logic lost_uncounted;
    assign ok_accept      = accept & frame_ok;
    assign lost_uncounted = frame_lost && (lost_total == '0 || failure_total == '0);

    `ASSERT_CLK(a_accept_gives_result, clk, rst_n, accept |=> out_valid, "no result")
    `ASSERT_CLK(a_success_not_lost, clk, rst_n, ok_accept |=> !frame_lost, "lost on success")
    `ASSERT_NEVER(a_lost_counted, clk, rst_n, out_valid && lost_uncounted, "lost not counted")

endmodule
